### design/toy_risc_core_step_macros.svh
// Assertion macros for the toy RISC core step block.
// Used by design/toy_risc_core_step.sv; expects i_clk and i_rst_n in scope.
`ifndef TOY_RISC_CORE_STEP_MACROS_SVH
`define TOY_RISC_CORE_STEP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define TRC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### design/trc_pkg.sv
// Package for the toy RISC core step block: sizes, opcodes, status codes, states.
// No dependencies.
package trc_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;

    localparam logic [2:0] STAT_OK     = 3'd0;
    localparam logic [2:0] STAT_HALT   = 3'd1;
    localparam logic [2:0] STAT_DIVZ   = 3'd2;
    localparam logic [2:0] STAT_BADOP  = 3'd3;
    localparam logic [2:0] STAT_UNSUPP = 3'd4;

    typedef enum logic [4:0] {
        OP_OR   = 5'd0,
        OP_AND  = 5'd1,
        OP_XOR  = 5'd2,
        OP_ADD  = 5'd3,
        OP_SUB  = 5'd4,
        OP_MUL  = 5'd5,
        OP_DIV  = 5'd6,
        OP_SHF  = 5'd7,
        OP_LDB  = 5'd12,
        OP_LDH  = 5'd13,
        OP_LDW  = 5'd14,
        OP_STB  = 5'd15,
        OP_STH  = 5'd16,
        OP_STW  = 5'd17,
        OP_JMP  = 5'd21,
        OP_JZ   = 5'd22,
        OP_JNZ  = 5'd23,
        OP_JC   = 5'd24,
        OP_JNC  = 5'd25,
        OP_JN   = 5'd26,
        OP_JNN  = 5'd27,
        OP_IN   = 5'd28,
        OP_OUT  = 5'd29,
        OP_RND  = 5'd30,
        OP_HALT = 5'd31
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FETCH,
        ST_FLAST,
        ST_RA,
        ST_RB,
        ST_RD,
        ST_EX,
        ST_DIV,
        ST_DEND,
        ST_MRD,
        ST_MLAST,
        ST_STORE,
        ST_OUT
    } t_state;

endpackage

### design/toy_risc_core_step.sv
// Top level of the toy RISC core step block: sequencer, byte memory, register file.
// Depends on trc_pkg and toy_risc_core_step_macros.svh.
`include "toy_risc_core_step_macros.svh"

// One request is either a program-word load or the execution of one instruction,
// and each gives exactly one result. Requests are taken one at a time. State sits
// in a byte memory and a 32-entry register file, both with registered reads, so
// the sequencer moves a byte or a register a cycle. A load writes its word a byte
// at a time and then posts the result. A step fetches the word, reads rn, src2
// and rd in turn, executes and posts. Memory loads and stores move their bytes
// one a cycle; divide runs a restoring shift-subtract divider, one quotient bit a
// cycle. After posting, the sequencer returns to idle to take the next request,
// so a new request is accepted only once the last one has been posted. A result
// waits in the output register while the next request is already accepted; the
// block posts its next result only once that register is free. Register file
// entries are valid-bit tracked so that reset clears them at once; the byte
// memory has no reset.
module toy_risc_core_step
    import trc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // load_addr[15:0], load_word[47:16], in_value[79:48]
    input  logic [79:0] i_s_tdata,
    // cmd[0]
    input  logic [0:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[2:0], out_valid[3], out_value[35:4], in_used[36], next_pc[52:37],
    // flags_znc[55:53]
    output logic [55:0] o_m_tdata
);

    // Storage
    logic [7:0]  r_mem [MEM_BYTES];
    logic [31:0] r_rf  [REG_COUNT];
    logic [REG_COUNT-1:0] r_rfv;
    logic [7:0]  r_mem_q;
    logic [31:0] r_rf_q;
    logic        r_rf_qv;

    // Sequencer and architectural registers
    t_state      r_state, n_state;
    logic [1:0]  r_cnt, n_cnt;
    logic [31:0] r_ir, n_ir;
    logic [31:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [31:0] r_ld, n_ld;
    logic [31:0] r_addr, n_addr;
    logic [1:0]  r_nbm1, n_nbm1;
    logic        r_cmd, n_cmd;
    logic [15:0] r_laddr, n_laddr;
    logic [31:0] r_lword, n_lword;
    logic [31:0] r_inval, n_inval;
    logic [15:0] r_pc, n_pc;
    logic        r_z, n_z, r_n, n_n, r_c, n_c;
    logic [2:0]  r_status, n_status;
    logic        r_ov, n_ov, r_iu, n_iu;
    logic [31:0] r_oval, n_oval;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dvs, n_dvs;
    logic        r_dneg, n_dneg;
    logic [4:0]  r_dcnt, n_dcnt;
    logic        r_o_vld, n_o_vld;
    logic [55:0] r_o_data, n_o_data;

    // Port controls
    logic [MEM_AW-1:0] mem_raddr, mem_waddr;
    logic              mem_we;
    logic [7:0]        mem_wdata;
    logic [REG_AW-1:0] rf_raddr, rf_waddr;
    logic              rf_we;
    logic [31:0]       rf_wdata;

    // Decode of the held instruction word
    t_op         op;
    logic [4:0]  f_rd, f_rn, f_src2;
    logic [31:0] imm, bop, rf_rd;
    logic [31:0] fetch_sum, mrd_sum, ld_sum, st_sum;

    assign op     = t_op'(r_ir[31:27]);
    assign f_rd   = r_ir[26:22];
    assign f_rn   = r_ir[21:17];
    assign f_src2 = r_ir[4:0];
    assign imm    = {{16{r_ir[15]}}, r_ir[15:0]};
    assign bop    = r_ir[16] ? imm : r_b;
    assign rf_rd  = r_rf_qv ? r_rf_q : 32'd0;

    // ALU for the logic, add, subtract, multiply and shift operations
    logic [31:0] alu_res;
    logic        alu_c;
    logic [32:0] sum33, dif33;
    logic [31:0] k_neg;

    always_comb begin
        sum33   = {r_a[31], r_a} + {bop[31], bop};
        dif33   = {r_a[31], r_a} - {bop[31], bop};
        k_neg   = 32'd0 - bop;
        alu_res = 32'd0;
        alu_c   = r_c;
        unique case (op)
            OP_OR:  alu_res = r_a | bop;
            OP_AND: alu_res = r_a & bop;
            OP_XOR: alu_res = r_a ^ bop;
            OP_ADD: begin
                alu_res = sum33[31:0];
                alu_c   = sum33[32];
            end
            OP_SUB: begin
                alu_res = dif33[31:0];
                alu_c   = dif33[32];
            end
            OP_MUL: begin
                alu_res = r_a[15:0] * bop[15:0];
                alu_c   = 1'b0;
            end
            OP_SHF: begin
                if (bop == 32'd0) begin
                    alu_res = r_a;
                    alu_c   = 1'b0;
                end else if (!bop[31]) begin
                    if (bop > 32'd32) begin
                        alu_res = 32'd0;
                        alu_c   = 1'b0;
                    end else if (bop == 32'd32) begin
                        alu_res = 32'd0;
                        alu_c   = r_a[31];
                    end else begin
                        alu_res = r_a >> bop[4:0];
                        alu_c   = r_a[bop[4:0] - 5'd1];
                    end
                end else begin
                    if (k_neg > 32'd32) begin
                        alu_res = 32'd0;
                        alu_c   = 1'b0;
                    end else if (k_neg == 32'd32) begin
                        alu_res = 32'd0;
                        alu_c   = r_a[0];
                    end else begin
                        alu_res = r_a << k_neg[4:0];
                        alu_c   = r_a[5'd0 - k_neg[4:0]];
                    end
                end
            end
            default: alu_res = 32'd0;
        endcase
    end

    // Divider step
    logic [32:0] rem_sh, rem_dif;
    assign rem_sh  = {r_rem, r_quo[31]};
    assign rem_dif = rem_sh - {1'b0, r_dvs};

    assign fetch_sum = {16'd0, r_pc} + {30'd0, r_cnt};
    assign mrd_sum   = r_addr + {30'd0, r_cnt};
    assign ld_sum    = {16'd0, r_laddr} + {30'd0, r_cnt};
    assign st_sum    = r_addr + {30'd0, r_cnt};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ir     = r_ir;
        n_a      = r_a;
        n_b      = r_b;
        n_ld     = r_ld;
        n_addr   = r_addr;
        n_nbm1   = r_nbm1;
        n_cmd    = r_cmd;
        n_laddr  = r_laddr;
        n_lword  = r_lword;
        n_inval  = r_inval;
        n_pc     = r_pc;
        n_z      = r_z;
        n_n      = r_n;
        n_c      = r_c;
        n_status = r_status;
        n_ov     = r_ov;
        n_oval   = r_oval;
        n_iu     = r_iu;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dvs    = r_dvs;
        n_dneg   = r_dneg;
        n_dcnt   = r_dcnt;
        n_o_vld  = r_o_vld && !i_m_tready;
        n_o_data = r_o_data;
        o_s_tready = 1'b0;
        mem_raddr = fetch_sum[MEM_AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = ld_sum[MEM_AW-1:0];
        mem_wdata = r_lword[{~r_cnt, 3'b000} +: 8];
        rf_raddr  = f_rn;
        rf_we     = 1'b0;
        rf_waddr  = f_rd;
        rf_wdata  = alu_res;

        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_cmd    = i_s_tuser[0];
                    n_laddr  = i_s_tdata[15:0];
                    n_lword  = i_s_tdata[47:16];
                    n_inval  = i_s_tdata[79:48];
                    n_status = STAT_OK;
                    n_ov     = 1'b0;
                    n_oval   = 32'd0;
                    n_iu     = 1'b0;
                    n_cnt    = 2'd0;
                    n_state  = i_s_tuser[0] ? ST_FETCH : ST_LOAD;
                end
            end
            ST_LOAD: begin
                // write one byte of the program word a cycle, high byte first
                mem_we = 1'b1;
                n_cnt  = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = ST_OUT;
                end
            end
            ST_FETCH: begin
                if (r_cnt != 2'd0) begin
                    n_ir = {r_ir[23:0], r_mem_q};
                end
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = ST_FLAST;
                end
            end
            ST_FLAST: begin
                n_ir    = {r_ir[23:0], r_mem_q};
                n_state = ST_RA;
            end
            ST_RA: begin
                rf_raddr = f_rn;
                n_state  = ST_RB;
            end
            ST_RB: begin
                rf_raddr = f_src2;
                n_a      = rf_rd;
                n_state  = ST_RD;
            end
            ST_RD: begin
                rf_raddr = f_rd;
                n_b      = rf_rd;
                n_state  = ST_EX;
            end
            ST_EX: begin
                n_state = ST_OUT;
                n_cnt   = 2'd0;
                unique case (op)
                    OP_OR, OP_AND, OP_XOR, OP_ADD, OP_SUB, OP_MUL, OP_SHF: begin
                        rf_we    = (f_rd != 5'd0);
                        rf_wdata = alu_res;
                        n_z      = (alu_res == 32'd0);
                        n_n      = alu_res[31];
                        n_c      = alu_c;
                        n_pc     = r_pc + 16'd4;
                    end
                    OP_DIV: begin
                        if (bop == 32'd0) begin
                            n_status = STAT_DIVZ;
                        end else begin
                            n_quo   = r_a[31] ? 32'd0 - r_a : r_a;
                            n_dvs   = bop[31] ? 32'd0 - bop : bop;
                            n_rem   = 32'd0;
                            n_dneg  = r_a[31] ^ bop[31];
                            n_dcnt  = 5'd0;
                            n_state = ST_DIV;
                        end
                    end
                    OP_LDB, OP_LDH, OP_LDW: begin
                        n_addr  = r_a + bop;
                        n_nbm1  = (op == OP_LDB) ? 2'd0 : ((op == OP_LDH) ? 2'd1 : 2'd3);
                        n_state = ST_MRD;
                    end
                    OP_STB, OP_STH, OP_STW: begin
                        n_addr  = rf_rd + bop;
                        n_nbm1  = (op == OP_STB) ? 2'd0 : ((op == OP_STH) ? 2'd1 : 2'd3);
                        n_z     = (r_a == 32'd0);
                        n_n     = r_a[31];
                        n_state = ST_STORE;
                    end
                    OP_JMP, OP_JZ, OP_JNZ, OP_JC, OP_JNC, OP_JN, OP_JNN: begin
                        if ((op == OP_JMP) || (op == OP_JZ && r_z) || (op == OP_JNZ && !r_z)
                            || (op == OP_JC && r_c) || (op == OP_JNC && !r_c)
                            || (op == OP_JN && r_n) || (op == OP_JNN && !r_n)) begin
                            n_pc = bop[15:0];
                        end else begin
                            n_pc = r_pc + 16'd4;
                        end
                    end
                    OP_IN: begin
                        rf_we    = (f_rd != 5'd0);
                        rf_wdata = r_inval;
                        n_iu     = 1'b1;
                        n_pc     = r_pc + 16'd4;
                    end
                    OP_OUT: begin
                        n_ov   = 1'b1;
                        n_oval = rf_rd;
                        n_pc   = r_pc + 16'd4;
                    end
                    OP_RND:  n_status = STAT_UNSUPP;
                    OP_HALT: n_status = STAT_HALT;
                    default: n_status = STAT_BADOP;
                endcase
            end
            ST_DIV: begin
                // one quotient bit a cycle, restoring
                if (!rem_dif[32]) begin
                    n_rem = rem_dif[31:0];
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = rem_sh[31:0];
                    n_quo = {r_quo[30:0], 1'b0};
                end
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) begin
                    n_state = ST_DEND;
                end
            end
            ST_DEND: begin
                rf_we    = (f_rd != 5'd0);
                rf_wdata = r_dneg ? 32'd0 - r_quo : r_quo;
                n_z      = (rf_wdata == 32'd0);
                n_n      = rf_wdata[31];
                n_c      = 1'b0;
                n_pc     = r_pc + 16'd4;
                n_state  = ST_OUT;
            end
            ST_MRD: begin
                mem_raddr = mrd_sum[MEM_AW-1:0];
                if (r_cnt != 2'd0) begin
                    n_ld = {r_ld[23:0], r_mem_q};
                end
                if (r_cnt == r_nbm1) begin
                    n_state = ST_MLAST;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            ST_MLAST: begin
                unique case (r_nbm1)
                    2'd0:    rf_wdata = {{24{r_mem_q[7]}}, r_mem_q};
                    2'd1:    rf_wdata = {{16{r_ld[7]}}, r_ld[7:0], r_mem_q};
                    default: rf_wdata = {r_ld[23:0], r_mem_q};
                endcase
                rf_we   = (f_rd != 5'd0);
                n_z     = (rf_wdata == 32'd0);
                n_n     = rf_wdata[31];
                n_pc    = r_pc + 16'd4;
                n_state = ST_OUT;
            end
            ST_STORE: begin
                // high byte of the stored part goes to the lowest address
                mem_we    = 1'b1;
                mem_waddr = st_sum[MEM_AW-1:0];
                mem_wdata = r_a[{r_nbm1 - r_cnt, 3'b000} +: 8];
                if (r_cnt == r_nbm1) begin
                    n_pc    = r_pc + 16'd4;
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            ST_OUT: begin
                // post the result once the output register is free
                if (!r_o_vld || i_m_tready) begin
                    n_o_vld  = 1'b1;
                    n_o_data = {r_z, r_n, r_c, r_pc, r_iu, r_oval, r_ov, r_status};
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_raddr];
        if (rf_we) begin
            r_rf[rf_waddr] <= rf_wdata;
        end
        r_rf_q <= r_rf[rf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rfv   <= '0;
            r_rf_qv <= 1'b0;
            r_pc    <= 16'd0;
            r_z     <= 1'b0;
            r_n     <= 1'b0;
            r_c     <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (rf_we) begin
                r_rfv[rf_waddr] <= 1'b1;
            end
            r_rf_qv <= r_rfv[rf_raddr];
            r_pc    <= n_pc;
            r_z     <= n_z;
            r_n     <= n_n;
            r_c     <= n_c;
            r_o_vld <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_ir     <= n_ir;
        r_a      <= n_a;
        r_b      <= n_b;
        r_ld     <= n_ld;
        r_addr   <= n_addr;
        r_nbm1   <= n_nbm1;
        r_cmd    <= n_cmd;
        r_laddr  <= n_laddr;
        r_lword  <= n_lword;
        r_inval  <= n_inval;
        r_status <= n_status;
        r_ov     <= n_ov;
        r_oval   <= n_oval;
        r_iu     <= n_iu;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_dvs    <= n_dvs;
        r_dneg   <= n_dneg;
        r_dcnt   <= n_dcnt;
        r_o_data <= n_o_data;
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_data;

    // a load request must go to the byte writer, a step to the fetch
    `TRC_ASSERT_NEXT(a_accept_route, i_s_tvalid && o_s_tready,
        (r_cmd && r_state == ST_FETCH) || (!r_cmd && r_state == ST_LOAD),
        "accepted request not routed by its command")
    // register zero is never written
    `TRC_ASSERT(a_r0_clean, !r_rfv[0], "register zero marked written")
    // a result is posted only from the posting state
    `TRC_ASSERT_NEXT(a_post_src, !r_o_vld, !r_o_vld || $past(r_state) == ST_OUT,
        "result posted outside the posting state")

endmodule

### verif/toy_risc_core_step_tb.sv
// Self-checking testbench for toy_risc_core_step: program loads and single-step
// execution, checked request by request against an in-bench model of the core.
// Depends on trc_pkg and the toy_risc_core_step RTL.
`timescale 1ns / 1ps

module toy_risc_core_step_tb
    import trc_pkg::*;
();

    localparam int N_REQUESTS = 850;
    localparam int STALL_LIMIT = 20000;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Opcodes outside the instruction set
    localparam logic [4:0] OPC_UNDEF_A = 5'd8;
    localparam logic [4:0] OPC_UNDEF_B = 5'd19;

    // Fields from the lowest bit up: status, out_valid, out_value, in_used,
    // next_pc, flags_znc
    typedef struct packed {
        logic [2:0]  flags_znc;
        logic [15:0] next_pc;
        logic        in_used;
        logic [31:0] out_value;
        logic        out_valid;
        logic [2:0]  status;
    } t_core_result;

    typedef struct packed {
        logic         cmd;
        logic [15:0]  load_addr;
        logic [31:0]  load_word;
        logic [31:0]  in_value;
        logic         hold;
        t_core_result res;
    } t_core_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [79:0] i_s_tdata;
    logic [0:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [55:0] o_m_tdata;

    toy_risc_core_step dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Core model state, advanced as requests are generated (results are in order)
    logic [7:0]  core_mem [0:65535];
    bit          mem_written [0:65535];
    logic [31:0] core_regs [0:31];
    logic [15:0] core_pc;
    logic        flag_z, flag_n, flag_c;

    t_core_request request_q [$];
    t_core_result  result_q [$];
    int  err_count = 0;
    int  n_generated;
    int  n_accepted = 0;
    int  quiet_cycles = 0;
    bit  hold_next;
    bit  req_taken = 1'b0;

    t_op plain_ops [22] = '{OP_OR, OP_AND, OP_XOR, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                            OP_SHF, OP_LDB, OP_LDH, OP_LDW, OP_STB, OP_STH, OP_STW,
                            OP_JMP, OP_JZ, OP_JNZ, OP_JC, OP_JNC, OP_JN, OP_JNN,
                            OP_IN};

    function automatic logic [31:0] enc(logic [4:0] op, logic [4:0] rd, logic [4:0] rn,
                                        logic s, logic [15:0] imm);
        return {op, rd, rn, s, imm};
    endfunction

    function automatic logic [31:0] mem_word(logic [31:0] a);
        return {core_mem[a[15:0]], core_mem[16'(a + 1)], core_mem[16'(a + 2)],
                core_mem[16'(a + 3)]};
    endfunction

    function automatic void mem_put(logic [31:0] a, logic [7:0] v);
        core_mem[a[15:0]] = v;
        mem_written[a[15:0]] = 1'b1;
    endfunction

    function automatic void write_rd(logic [4:0] rd, logic [31:0] v);
        if (rd != 5'd0) core_regs[rd] = v;
    endfunction

    function automatic void set_zn(logic [31:0] v);
        flag_z = (v == 32'd0);
        flag_n = v[31];
    endfunction

    // Second operand of an instruction word: sign-extended immediate or src2 register
    function automatic logic [31:0] operand_b(logic [31:0] w);
        return w[16] ? {{16{w[15]}}, w[15:0]} : core_regs[w[4:0]];
    endfunction

    // Advance the core model by one request and return its result
    function automatic t_core_result core_apply(logic cmd, logic [15:0] la,
                                                logic [31:0] lw, logic [31:0] inv);
        t_core_result r;
        logic [31:0] w, a, b, res, ma, mb, q, addr, k;
        logic [32:0] wide;
        logic [4:0]  op, rd;
        logic [15:0] npc;
        logic        take;
        r = '0;
        if (cmd == CMD_LOAD) begin
            mem_put(la, lw[31:24]);
            mem_put(la + 1, lw[23:16]);
            mem_put(la + 2, lw[15:8]);
            mem_put(la + 3, lw[7:0]);
        end else begin
            w = mem_word(core_pc);
            op = w[31:27];
            rd = w[26:22];
            a = core_regs[w[21:17]];
            b = operand_b(w);
            npc = core_pc + 16'd4;
            take = 1'b0;
            case (op)
                OP_OR:  begin res = a | b; write_rd(rd, res); set_zn(res); end
                OP_AND: begin res = a & b; write_rd(rd, res); set_zn(res); end
                OP_XOR: begin res = a ^ b; write_rd(rd, res); set_zn(res); end
                OP_ADD: begin
                    wide = {a[31], a} + {b[31], b};
                    res = wide[31:0]; write_rd(rd, res); set_zn(res);
                    flag_c = wide[32];
                end
                OP_SUB: begin
                    wide = {a[31], a} - {b[31], b};
                    res = wide[31:0]; write_rd(rd, res); set_zn(res);
                    flag_c = wide[32];
                end
                OP_MUL: begin
                    res = {16'd0, a[15:0]} * {16'd0, b[15:0]};
                    write_rd(rd, res); set_zn(res); flag_c = 1'b0;
                end
                OP_DIV: begin
                    if (b == 32'd0) begin
                        r.status = STAT_DIVZ;
                    end else begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        res = (a[31] ^ b[31]) ? -q : q;
                        write_rd(rd, res); set_zn(res); flag_c = 1'b0;
                    end
                end
                OP_SHF: begin
                    // positive amount shifts right, negative shifts left
                    if (b == 32'd0) begin
                        res = a; flag_c = 1'b0;
                    end else if (!b[31]) begin
                        k = b;
                        if (k > 32) begin res = 0; flag_c = 1'b0; end
                        else if (k == 32) begin res = 0; flag_c = a[31]; end
                        else begin res = a >> k; flag_c = a[k - 1]; end
                    end else begin
                        k = -b;
                        if (k > 32) begin res = 0; flag_c = 1'b0; end
                        else if (k == 32) begin res = 0; flag_c = a[0]; end
                        else begin res = a << k; flag_c = a[32 - k]; end
                    end
                    write_rd(rd, res); set_zn(res);
                end
                OP_LDB: begin
                    addr = a + b;
                    res = {{24{core_mem[addr[15:0]][7]}}, core_mem[addr[15:0]]};
                    write_rd(rd, res); set_zn(res);
                end
                OP_LDH: begin
                    addr = a + b;
                    res = {{16{core_mem[addr[15:0]][7]}}, core_mem[addr[15:0]],
                           core_mem[16'(addr + 1)]};
                    write_rd(rd, res); set_zn(res);
                end
                OP_LDW: begin
                    res = mem_word(a + b); write_rd(rd, res); set_zn(res);
                end
                OP_STB, OP_STH, OP_STW: begin
                    addr = core_regs[rd] + b;
                    if (op == OP_STB) begin
                        mem_put(addr, a[7:0]);
                    end else if (op == OP_STH) begin
                        mem_put(addr, a[15:8]); mem_put(addr + 1, a[7:0]);
                    end else begin
                        mem_put(addr, a[31:24]); mem_put(addr + 1, a[23:16]);
                        mem_put(addr + 2, a[15:8]); mem_put(addr + 3, a[7:0]);
                    end
                    set_zn(a);
                end
                OP_JMP: take = 1'b1;
                OP_JZ:  take = flag_z;
                OP_JNZ: take = !flag_z;
                OP_JC:  take = flag_c;
                OP_JNC: take = !flag_c;
                OP_JN:  take = flag_n;
                OP_JNN: take = !flag_n;
                OP_IN: begin write_rd(rd, inv); r.in_used = 1'b1; end
                OP_OUT: begin r.out_valid = 1'b1; r.out_value = core_regs[rd]; end
                OP_RND:  r.status = STAT_UNSUPP;
                OP_HALT: r.status = STAT_HALT;
                default: r.status = STAT_BADOP;
            endcase
            if (take) npc = b[15:0];
            if (r.status == STAT_OK) core_pc = npc;
        end
        r.next_pc = core_pc;
        r.flags_znc = {flag_z, flag_n, flag_c};
        return r;
    endfunction

    function automatic void queue_request(logic cmd, logic [15:0] la, logic [31:0] lw,
                                          logic [31:0] inv);
        t_core_request q;
        q.cmd = cmd;
        q.load_addr = la;
        q.load_word = lw;
        q.in_value = inv;
        q.hold = hold_next;
        hold_next = 1'b0;
        q.res = core_apply(cmd, la, lw, inv);
        request_q.push_back(q);
        n_generated++;
    endfunction

    // Fill unwritten bytes a memory load would read, keeping bytes already written
    function automatic void cover_load_bytes(logic [31:0] w);
        logic [31:0] ea, fill;
        logic [7:0]  bv;
        int nb;
        bit gap;
        nb = (w[31:27] == OP_LDB) ? 1 : (w[31:27] == OP_LDH) ? 2 :
             (w[31:27] == OP_LDW) ? 4 : 0;
        if (nb == 0) return;
        ea = core_regs[w[21:17]] + operand_b(w);
        gap = 1'b0;
        for (int i = 0; i < nb; i++) if (!mem_written[16'(ea + i)]) gap = 1'b1;
        if (!gap) return;
        for (int i = 0; i < 4; i++) begin
            bv = mem_written[16'(ea + i)] ? core_mem[16'(ea + i)] : 8'($urandom);
            fill = {fill[23:0], bv};
        end
        queue_request(CMD_LOAD, ea[15:0], fill, $urandom);
    endfunction

    // Place an instruction at the PC (unless reusing what is there) and step it
    function automatic void issue_step(logic [31:0] w, logic [31:0] inv, bit fresh);
        cover_load_bytes(w);
        if (fresh) queue_request(CMD_LOAD, core_pc, w, $urandom);
        queue_request(CMD_STEP, 16'($urandom), $urandom, inv);
    endfunction

    function automatic logic [15:0] pick_imm();
        logic [15:0] corner [8] = '{16'h0000, 16'h0001, 16'h001F, 16'h0020, 16'h0021,
                                    16'hFFFF, 16'h8000, 16'h7FFF};
        int r;
        r = $urandom_range(99);
        if (r < 50) return 16'($urandom);
        if (r < 75) return 16'($signed($urandom_range(80)) - 40);
        return corner[$urandom_range(7)];
    endfunction

    function automatic logic [31:0] pick_instr();
        logic [4:0] op;
        if ($urandom_range(99) < 88) op = plain_ops[$urandom_range(21)];
        else op = 5'($urandom_range(31));
        if ($urandom_range(99) < 8) op = OP_OUT;
        return enc(op, 5'($urandom), 5'($urandom), 1'($urandom), pick_imm());
    endfunction

    function automatic logic [31:0] pick_in_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(64));
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got 0x%0h, want 0x%0h at %0t", field, got, want, $realtime);
        err_count++;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Idle percentages per phase: sender, receiver
    function automatic int tx_idle_pct();
        return (n_accepted < N_REQUESTS / 3) ? 27 : (n_accepted < 2 * N_REQUESTS / 3) ? 83 : 0;
    endfunction

    function automatic int rx_idle_pct();
        return (n_accepted < N_REQUESTS / 3) ? 83 : (n_accepted < 2 * N_REQUESTS / 3) ? 27 : 0;
    endfunction

    // Driver: present requests at the falling edge; hold an unaccepted one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tuser  <= '0;
            i_m_tready <= 1'b0;
        end else begin
            if (!(i_s_tvalid && !req_taken)) begin
                if (request_q.size() > 0 && !(request_q[0].hold && result_q.size() > 0)
                        && $urandom_range(99) >= tx_idle_pct()) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {request_q[0].in_value, request_q[0].load_word,
                                   request_q[0].load_addr};
                    i_s_tuser  <= request_q[0].cmd;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct());
        end
    end

    // Monitor and request bookkeeping at the rising edge
    always @(posedge i_clk) begin
        t_core_result got, want;
        req_taken = i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[31:0], 32'd0);
            end else begin
                want = result_q.pop_front();
                if (got.status != want.status) report_mismatch("status", got.status, want.status);
                if (got.out_valid != want.out_valid)
                    report_mismatch("out_valid", got.out_valid, want.out_valid);
                if (got.out_value != want.out_value)
                    report_mismatch("out_value", got.out_value, want.out_value);
                if (got.in_used != want.in_used)
                    report_mismatch("in_used", got.in_used, want.in_used);
                if (got.next_pc != want.next_pc)
                    report_mismatch("next_pc", got.next_pc, want.next_pc);
                if (got.flags_znc != want.flags_znc)
                    report_mismatch("flags_znc", got.flags_znc, want.flags_znc);
            end
        end
        if (req_taken) begin
            result_q.push_back(request_q[0].res);
            void'(request_q.pop_front());
            n_accepted++;
        end
        // Watchdog: count cycles with work pending and nothing moving
        if (req_taken || (o_m_tvalid && i_m_tready) ||
                (request_q.size() == 0 && result_q.size() == 0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("toy_risc_core_step regression: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] w;
        bit reuse;
        int r;
        i_rst_n = 1'b0;
        n_generated = 0;
        hold_next = 1'b0;
        for (int i = 0; i < 65536; i++) begin
            core_mem[i] = 8'd0;
            mem_written[i] = 1'b0;
        end
        for (int i = 0; i < 32; i++) core_regs[i] = 32'd0;
        core_pc = 16'd0;
        {flag_z, flag_n, flag_c} = 3'b000;

        // Directed: extreme operands, opcodes of every group, error and wrap cases
        issue_step(enc(OP_IN, 5'd1, 5'd0, 1'b0, 16'd0), 32'h8000_0000, 1);
        issue_step(enc(OP_IN, 5'd2, 5'd0, 1'b0, 16'd0), 32'h7FFF_FFFF, 1);
        issue_step(enc(OP_IN, 5'd3, 5'd0, 1'b0, 16'd0), 32'hFFFF_FFFF, 1);
        issue_step(enc(OP_ADD, 5'd4, 5'd2, 1'b1, 16'd1), 0, 1);     // signed overflow
        issue_step(enc(OP_ADD, 5'd5, 5'd1, 1'b0, 16'd1), 0, 1);     // wraps to zero
        issue_step(enc(OP_SUB, 5'd6, 5'd1, 1'b1, 16'd1), 0, 1);
        issue_step(enc(OP_OR, 5'd0, 5'd1, 1'b0, 16'd2), 0, 1);      // rd zero still flags
        issue_step(enc(OP_AND, 5'd7, 5'd3, 1'b1, 16'h8000), 0, 1);
        issue_step(enc(OP_XOR, 5'd8, 5'd3, 1'b0, 16'd3), 0, 1);
        issue_step(enc(OP_MUL, 5'd9, 5'd3, 1'b0, 16'd3), 0, 1);
        issue_step(enc(OP_DIV, 5'd10, 5'd1, 1'b0, 16'd3), 0, 1);    // most negative by -1
        issue_step(enc(OP_DIV, 5'd10, 5'd1, 1'b0, 16'd0), 0, 1);    // divide by zero
        issue_step(enc(OP_DIV, 5'd10, 5'd2, 1'b1, 16'hFFF9), 0, 1);
        issue_step(enc(OP_SHF, 5'd11, 5'd1, 1'b1, 16'd32), 0, 1);
        issue_step(enc(OP_SHF, 5'd11, 5'd3, 1'b1, 16'hFFE0), 0, 1);
        issue_step(enc(OP_SHF, 5'd11, 5'd3, 1'b1, 16'd33), 0, 1);
        issue_step(enc(OP_SHF, 5'd11, 5'd2, 1'b1, 16'hFFFF), 0, 1);
        issue_step(enc(OP_STW, 5'd0, 5'd1, 1'b1, 16'hFFFE), 0, 1);  // wraps past the top
        issue_step(enc(OP_LDH, 5'd12, 5'd0, 1'b1, 16'hFFFF), 0, 1);
        issue_step(enc(OP_LDB, 5'd12, 5'd0, 1'b1, 16'hFFFE), 0, 1);
        issue_step(enc(OP_STB, 5'd3, 5'd2, 1'b1, 16'd9), 0, 1);
        issue_step(enc(OP_OUT, 5'd1, 5'd0, 1'b0, 16'd0), 0, 1);
        issue_step(enc(OP_RND, 5'd1, 5'd0, 1'b0, 16'd0), 0, 1);
        issue_step(enc(OP_HALT, 5'd0, 5'd0, 1'b0, 16'd0), 0, 1);
        issue_step(enc(OPC_UNDEF_A, 5'd0, 5'd0, 1'b0, 16'd0), 0, 1);
        issue_step(enc(OPC_UNDEF_B, 5'd0, 5'd0, 1'b0, 16'd0), 0, 1);
        issue_step(enc(OP_JMP, 5'd0, 5'd0, 1'b1, 16'hFFFD), 0, 1);  // odd target near top

        // Random: mostly fresh instructions, some re-execution of memory, some loads
        while (n_generated < N_REQUESTS) begin
            if (n_generated >= 300 && n_generated < 304) hold_next = 1'b1;
            r = $urandom_range(99);
            if (r < 5) begin
                queue_request(CMD_LOAD, 16'($urandom), $urandom, $urandom);
            end else begin
                reuse = (r < 20);
                for (int i = 0; i < 4; i++)
                    if (!mem_written[16'(core_pc + i)]) reuse = 1'b0;
                w = reuse ? mem_word(core_pc) : pick_instr();
                issue_step(w, pick_in_value(), !reuse);
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (request_q.size() == 0 && result_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (err_count == 0 && result_q.size() == 0) begin
            $display("toy_risc_core_step regression: pass");
        end else begin
            $display("toy_risc_core_step regression: fail");
        end
        $finish;
    end

endmodule
